@@ rtl/slpf_pkg.sv @@
// ----------------------------------------------------------------------------
// slpf_pkg
// shared types and constants for the long packet framer
// ----------------------------------------------------------------------------
package slpf_pkg;

  // record size and byte step widths cover the full MAX_RECORD_BYTES range (1..8)
  localparam int unsigned SIZE_W = 4;
  localparam int unsigned STEP_W = 5;

  localparam logic [7:0] SYNC_A = 8'hFA;
  localparam logic [7:0] SYNC_B = 8'hAF;

  // register indexes on the configuration port
  localparam logic [2:0] REG_HEADER_ID    = 3'd0;
  localparam logic [2:0] REG_HEADER_FLAGS = 3'd1;
  localparam logic [2:0] REG_MEM_ADDRESS  = 3'd2;
  localparam logic [2:0] REG_RECORD_SIZE  = 3'd3;
  localparam logic [2:0] REG_SERVO_COUNT  = 3'd4;

  // byte positions within one record's share of the stream
  localparam logic [STEP_W-1:0] STEP_SYNC_A = 5'd0;
  localparam logic [STEP_W-1:0] STEP_SYNC_B = 5'd1;
  localparam logic [STEP_W-1:0] STEP_HDR_ID = 5'd2;
  localparam logic [STEP_W-1:0] STEP_FLAGS  = 5'd3;
  localparam logic [STEP_W-1:0] STEP_MEM    = 5'd4;
  localparam logic [STEP_W-1:0] STEP_LEN    = 5'd5;
  localparam logic [STEP_W-1:0] STEP_COUNT  = 5'd6;
  localparam logic [STEP_W-1:0] STEP_ID     = 5'd7;
  localparam logic [STEP_W-1:0] STEP_PAY    = 5'd8;

  typedef struct packed {
    logic [7:0]        header_id;
    logic [7:0]        header_flags;
    logic [7:0]        mem_address;
    logic [7:0]        servo_count;
  } cfg_t;

  typedef struct packed {
    logic [7:0]        servo_id;
    logic [31:0]       payload;
    logic              hdr;
    logic              last;
    logic [SIZE_W-1:0] size;
  } rec_t;

endpackage

@@ rtl/slpf_front.sv @@
// ----------------------------------------------------------------------------
// slpf_front
// accepts servo records and tags them with header, close and size
// ----------------------------------------------------------------------------
module slpf_front import slpf_pkg::*; #(
  parameter int unsigned MAX_RECORD_BYTES = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] servo_id_i,
  input  logic [31:0] payload_i,
  input  logic [2:0] record_size_i,
  input  logic [7:0] servo_count_i,
  input  logic       q_full_i,
  output logic       push_o,
  output rec_t       rec_o
);

  localparam logic [SIZE_W-1:0] MaxSize = SIZE_W'(MAX_RECORD_BYTES);

  logic [7:0]        records_done_q, records_done_d;
  logic [8:0]        next_cnt;
  logic              close;
  logic [SIZE_W-1:0] req_size;

  assign push_o   = in_valid_i && !q_full_i;
  assign next_cnt = {1'b0, records_done_q} + 9'd1;
  assign close    = next_cnt >= {1'b0, servo_count_i};
  assign req_size = {{(SIZE_W-3){1'b0}}, record_size_i};

  always_comb begin
    rec_o.servo_id = servo_id_i;
    rec_o.payload  = payload_i;
    rec_o.hdr      = (records_done_q == 8'd0);
    rec_o.last     = close;
    rec_o.size     = (req_size > MaxSize) ? MaxSize : req_size;
  end

  always_comb begin
    records_done_d = records_done_q;
    if (push_o) begin
      records_done_d = close ? 8'd0 : next_cnt[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      records_done_q <= 8'd0;
    end else begin
      records_done_q <= records_done_d;
    end
  end

endmodule

@@ rtl/slpf_queue.sv @@
// ----------------------------------------------------------------------------
// slpf_queue
// two-entry record queue between the front and the byte sequencer
// ----------------------------------------------------------------------------
module slpf_queue import slpf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  rec_t rec_i,
  input  logic pop_i,
  output logic full_o,
  output logic valid_o,
  output rec_t rec_o
);

  rec_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign rec_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= rec_i;
    end
  end

endmodule

@@ rtl/slpf_back.sv @@
// ----------------------------------------------------------------------------
// slpf_back
// walks queued records one byte a cycle unless stalled, keeps the xor checksum
// ----------------------------------------------------------------------------
module slpf_back import slpf_pkg::*; #(
  parameter int unsigned MAX_RECORD_BYTES = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       q_valid_i,
  input  rec_t       rec_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       last_byte_o
);

  localparam logic [STEP_W-1:0] StepChk = STEP_W'(32'(STEP_PAY) + MAX_RECORD_BYTES);

  logic              active_q, active_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [STEP_W-1:0] cur_step;
  logic [STEP_W-1:0] body_end;
  logic [STEP_W-1:0] pay_idx;
  logic [7:0]        xor_q, xor_d;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        byte_q, byte_d;
  logic              last_q, last_d;
  logic              emit;
  logic              done;
  logic [7:0]        cur_byte;
  logic [7:0]        pay_byte;
  logic              summed;

  assign emit     = q_valid_i && (!out_valid_q || !out_stall_i);
  assign cur_step = active_q ? step_q : (rec_i.hdr ? STEP_SYNC_A : STEP_ID);
  assign body_end = STEP_ID + {{(STEP_W-SIZE_W){1'b0}}, rec_i.size};
  assign pay_idx  = cur_step - STEP_PAY;

  // payload bytes past the 32-bit word read as zero
  assign pay_byte = (pay_idx < 5'd4) ? rec_i.payload[{pay_idx[1:0], 3'b000} +: 8] : 8'h00;

  always_comb begin
    case (cur_step)
      STEP_SYNC_A: cur_byte = SYNC_A;
      STEP_SYNC_B: cur_byte = SYNC_B;
      STEP_HDR_ID: cur_byte = cfg_i.header_id;
      STEP_FLAGS:  cur_byte = cfg_i.header_flags;
      STEP_MEM:    cur_byte = cfg_i.mem_address;
      STEP_LEN:    cur_byte = {{(8-SIZE_W){1'b0}}, rec_i.size} + 8'd1;
      STEP_COUNT:  cur_byte = cfg_i.servo_count;
      STEP_ID:     cur_byte = rec_i.servo_id;
      default:     cur_byte = (cur_step == StepChk) ? xor_q : pay_byte;
    endcase
  end

  assign summed = (cur_step != STEP_SYNC_A) && (cur_step != STEP_SYNC_B) &&
                  (cur_step != StepChk);
  assign done   = (cur_step == StepChk) || ((cur_step == body_end) && !rec_i.last);
  assign pop_o  = emit && done;

  always_comb begin
    active_d    = active_q;
    step_d      = step_q;
    xor_d       = xor_q;
    byte_d      = byte_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (emit) begin
      out_valid_d = 1'b1;
      byte_d      = cur_byte;
      last_d      = (cur_step == StepChk);
      if (cur_step == StepChk) begin
        xor_d = 8'h00;
      end else if (summed) begin
        xor_d = xor_q ^ cur_byte;
      end
      if (done) begin
        active_d = 1'b0;
      end else begin
        active_d = 1'b1;
        step_d   = (cur_step == body_end) ? StepChk : cur_step + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      step_q      <= STEP_SYNC_A;
      xor_q       <= 8'h00;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      step_q      <= step_d;
      xor_q       <= xor_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = byte_q;
  assign last_byte_o = last_q;

endmodule

@@ rtl/servo_long_packet_framer.sv @@
// ----------------------------------------------------------------------------
// servo_long_packet_framer
// frames servo records into long command packets with an xor checksum
// ----------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  record   in         in_valid_i/in_stall_o   servo_id_i, payload_i
//  byte     out        out_valid_o/out_stall_i out_byte_o, last_byte_o
//  config   in         psel/penable/pwrite     paddr, pwdata, prdata
//
//  one output byte per cycle while out_stall_i is low: a record gives 1 + its
//  record size (capped at MAX_RECORD_BYTES) bytes, plus 7 header bytes on the
//  first record and 1 checksum byte on the last;
//  the byte sequencer is the limit, the front keeps filling a 2-entry queue
//  reset clears the record count, the checksum and the queue, no clear pass
//  out_stall_i holds a waiting output byte and the sequencer in place
// ----------------------------------------------------------------------------
module servo_long_packet_framer import slpf_pkg::*; #(
  parameter int unsigned MAX_RECORD_BYTES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  servo_id_i,
  input  logic [31:0] payload_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        last_byte_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] header_id_q, header_flags_q, mem_address_q, servo_count_q;
  logic [2:0] record_size_q;
  logic       wr_en;
  logic [2:0] reg_idx;
  cfg_t       cfg;
  rec_t       front_rec, q_rec;
  logic       push, pop, q_full, q_valid;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_id_q    <= 8'h00;
      header_flags_q <= 8'h00;
      mem_address_q  <= 8'h1E;
      record_size_q  <= 3'd4;
      servo_count_q  <= 8'd5;
    end else if (wr_en) begin
      case (reg_idx)
        REG_HEADER_ID:    header_id_q    <= pwdata[7:0];
        REG_HEADER_FLAGS: header_flags_q <= pwdata[7:0];
        REG_MEM_ADDRESS:  mem_address_q  <= pwdata[7:0];
        REG_RECORD_SIZE:  record_size_q  <= pwdata[2:0];
        REG_SERVO_COUNT:  servo_count_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_HEADER_ID:    prdata = {24'h0, header_id_q};
      REG_HEADER_FLAGS: prdata = {24'h0, header_flags_q};
      REG_MEM_ADDRESS:  prdata = {24'h0, mem_address_q};
      REG_RECORD_SIZE:  prdata = {29'h0, record_size_q};
      REG_SERVO_COUNT:  prdata = {24'h0, servo_count_q};
      default:          prdata = 32'h0;
    endcase
  end

  always_comb begin
    cfg.header_id    = header_id_q;
    cfg.header_flags = header_flags_q;
    cfg.mem_address  = mem_address_q;
    cfg.servo_count  = servo_count_q;
  end

  assign in_stall_o = q_full;

  slpf_front #(
    .MAX_RECORD_BYTES(MAX_RECORD_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .servo_id_i   (servo_id_i),
    .payload_i    (payload_i),
    .record_size_i(record_size_q),
    .servo_count_i(servo_count_q),
    .q_full_i     (q_full),
    .push_o       (push),
    .rec_o        (front_rec)
  );

  slpf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .rec_i  (front_rec),
    .pop_i  (pop),
    .full_o (q_full),
    .valid_o(q_valid),
    .rec_o  (q_rec)
  );

  slpf_back #(
    .MAX_RECORD_BYTES(MAX_RECORD_BYTES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .q_valid_i  (q_valid),
    .rec_i      (q_rec),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_byte_o (out_byte_o),
    .last_byte_o(last_byte_o)
  );

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// checks the long packet framer: servo records go in, the framed byte stream
// with header, per-record bytes and xor checksum comes out and is compared
// byte by byte against a local frame builder; directed rows, then random
// settings phases with sender gaps, receiver stalls and a long output hold
// ----------------------------------------------------------------------------
module tb_top import slpf_pkg::*; ();

  localparam int unsigned MAX_REC_BYTES = 4;
  localparam int          CYCLE_LIMIT   = 400000;
  localparam int          RANDOM_ITEMS  = 160;
  localparam int          HOLD_CYCLES   = 80;
  localparam int          TAIL_CYCLES   = 16;
  localparam int          MAX_PRINTS    = 40;

  typedef enum logic {ROW_RECORD, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [2:0]  sel;
    logic [7:0]  id;
    logic [31:0] data;
    logic [7:0]  n_bytes;
  } row_t;

  typedef struct packed {
    logic [7:0] value;
    logic       closes;
  } framed_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  servo_id_i;
  logic [31:0] payload_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  out_byte_o;
  logic        last_byte_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  servo_long_packet_framer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .servo_id_i  (servo_id_i),
    .payload_i   (payload_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .last_byte_o (last_byte_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // local copy of the settings and the framing state
  logic [7:0] hdr_id;
  logic [7:0] hdr_flags;
  logic [7:0] mem_addr;
  logic [2:0] rec_size;
  logic [7:0] pkt_count;
  logic [7:0] recs_done;
  logic [7:0] xsum;

  framed_t stream_q [$];
  framed_t head_byte;
  row_t    plan [$];

  int errors;
  int cycles;
  int records_sent;
  int bytes_seen;
  int packets_closed;
  int writes_done;
  bit no_idle;
  bit hold_req;
  int hold_left;
  int holds_done;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  task automatic report_miss(input string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("MISMATCH @%0d: %s", cycles, msg);
  endtask

  function automatic void put_octet(input logic [7:0] v, input logic closes,
                                    input bit summed);
    stream_q.push_back('{v, closes});
    if (summed) xsum = xsum ^ v;
  endfunction

  // expected bytes for one accepted record
  function automatic void frame_record(input logic [7:0] id, input logic [31:0] pay);
    int unsigned size;
    int unsigned nxt;
    size = (rec_size > MAX_REC_BYTES) ? MAX_REC_BYTES : rec_size;
    if (recs_done == 8'd0) begin
      xsum = 8'd0;
      put_octet(SYNC_A, 1'b0, 1'b0);
      put_octet(SYNC_B, 1'b0, 1'b0);
      put_octet(hdr_id, 1'b0, 1'b1);
      put_octet(hdr_flags, 1'b0, 1'b1);
      put_octet(mem_addr, 1'b0, 1'b1);
      put_octet(8'(size + 1), 1'b0, 1'b1);
      put_octet(pkt_count, 1'b0, 1'b1);
    end
    put_octet(id, 1'b0, 1'b1);
    for (int k = 0; k < size; k++) put_octet(pay[8*k +: 8], 1'b0, 1'b1);
    nxt = recs_done + 1;
    if (nxt >= pkt_count) begin
      put_octet(xsum, 1'b1, 1'b0);
      recs_done = 8'd0;
      xsum = 8'd0;
    end else begin
      recs_done = 8'(nxt);
    end
  endfunction

  function automatic row_t rec_row(input logic [7:0] id, input logic [31:0] pay,
                                   input logic [7:0] n);
    row_t r;
    r = '{ROW_RECORD, REG_HEADER_ID, id, pay, n};
    return r;
  endfunction

  function automatic row_t cfg_row(input logic [2:0] sel, input logic [31:0] val);
    row_t r;
    r = '{ROW_WRITE, sel, 8'h00, val, 8'd0};
    return r;
  endfunction

  // all tasks below start and end just after a falling edge
  task automatic push_record(input logic [7:0] id, input logic [31:0] pay,
                             output int n_pred);
    int pending0;
    while (!no_idle && $urandom_range(99) < 13) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    servo_id_i <= id;
    payload_i  <= pay;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending0 = stream_q.size();
    frame_record(id, pay);
    n_pred = stream_q.size() - pending0;
    records_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (stream_q.size() != 0);
  endtask

  task automatic cfg_write(input logic [2:0] sel, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (sel)
      REG_HEADER_ID:    hdr_id    = val[7:0];
      REG_HEADER_FLAGS: hdr_flags = val[7:0];
      REG_MEM_ADDRESS:  mem_addr  = val[7:0];
      REG_RECORD_SIZE:  rec_size  = val[2:0];
      REG_SERVO_COUNT:  pkt_count = val[7:0];
      default: ;
    endcase
    writes_done++;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic random_settings;
    int r;
    logic [2:0] rs;
    logic [7:0] cnt;
    r  = $urandom_range(9);
    rs = (r < 8) ? 3'($urandom_range(4, 1)) : 3'($urandom_range(7));
    r  = $urandom_range(19);
    if (r < 14)      cnt = 8'($urandom_range(6, 1));
    else if (r < 17) cnt = 8'd0;
    else             cnt = 8'($urandom_range(255, 7));
    cfg_write(REG_HEADER_ID, 32'($urandom_range(255)));
    cfg_write(REG_HEADER_FLAGS, 32'($urandom_range(255)));
    cfg_write(REG_MEM_ADDRESS, 32'($urandom_range(255)));
    cfg_write(REG_RECORD_SIZE, 32'(rs));
    cfg_write(REG_SERVO_COUNT, 32'(cnt));
  endtask

  // byte stream receiver: random stalls, plus one long hold on request
  initial begin
    out_stall_i = 1'b0;
    hold_left   = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (no_idle) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < 13);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      bytes_seen++;
      if (last_byte_o) packets_closed++;
      if (stream_q.size() == 0) begin
        report_miss($sformatf("byte %02h last %0b with nothing pending",
                              out_byte_o, last_byte_o));
      end else begin
        head_byte = stream_q.pop_front();
        if (out_byte_o !== head_byte.value)
          report_miss($sformatf("out_byte %02h, want %02h", out_byte_o, head_byte.value));
        if (last_byte_o !== head_byte.closes)
          report_miss($sformatf("last_byte %0b, want %0b on byte %02h",
                                last_byte_o, head_byte.closes, head_byte.value));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout with %0d bytes still pending", stream_q.size());
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    int n_pred;
    int n_recs;
    int phase;
    int rand_sent;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    servo_id_i  = 8'h00;
    payload_i   = 32'h0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = 5'd0;
    pwdata      = 32'h0;
    hdr_id      = 8'h00;
    hdr_flags   = 8'h00;
    mem_addr    = 8'h1E;
    rec_size    = 3'd4;
    pkt_count   = 8'd5;
    recs_done   = 8'd0;
    xsum        = 8'd0;
    no_idle     = 1'b0;
    hold_req    = 1'b0;

    // after reset: four byte records, five per packet
    plan.push_back(rec_row(8'h00, 32'h0000_0000, 8'd12));
    plan.push_back(rec_row(8'hFF, 32'hFFFF_FFFF, 8'd5));
    plan.push_back(rec_row(8'h5A, 32'h1234_5678, 8'd5));
    plan.push_back(rec_row(8'hA5, 32'hA5A5_A5A5, 8'd5));
    plan.push_back(rec_row(8'h01, 32'h8000_0001, 8'd6));
    // id-only records, single record packets
    plan.push_back(cfg_row(REG_RECORD_SIZE, 32'd0));
    plan.push_back(cfg_row(REG_SERVO_COUNT, 32'd1));
    plan.push_back(rec_row(8'h3C, 32'hDEAD_BEEF, 8'd9));
    // oversized record clamps to four payload bytes
    plan.push_back(cfg_row(REG_RECORD_SIZE, 32'd7));
    plan.push_back(rec_row(8'hC3, 32'h0102_0304, 8'd13));
    // zero count closes after one record
    plan.push_back(cfg_row(REG_SERVO_COUNT, 32'd0));
    plan.push_back(cfg_row(REG_RECORD_SIZE, 32'd1));
    plan.push_back(rec_row(8'h7E, 32'hFFFF_FF00, 8'd10));
    // header fields at their top values, then the count drops below records done
    plan.push_back(cfg_row(REG_HEADER_ID, 32'hFF));
    plan.push_back(cfg_row(REG_HEADER_FLAGS, 32'hFF));
    plan.push_back(cfg_row(REG_MEM_ADDRESS, 32'hFF));
    plan.push_back(cfg_row(REG_SERVO_COUNT, 32'hFF));
    plan.push_back(cfg_row(REG_RECORD_SIZE, 32'd5));
    plan.push_back(rec_row(8'h80, 32'h0000_0080, 8'd12));
    plan.push_back(rec_row(8'h7F, 32'hFFFF_FFFF, 8'd5));
    plan.push_back(cfg_row(REG_SERVO_COUNT, 32'd1));
    plan.push_back(rec_row(8'h55, 32'h55AA_55AA, 8'd6));
    plan.push_back(cfg_row(REG_MEM_ADDRESS, 32'h00));
    plan.push_back(cfg_row(REG_RECORD_SIZE, 32'd2));
    plan.push_back(cfg_row(REG_SERVO_COUNT, 32'd2));
    plan.push_back(rec_row(8'h00, 32'h0000_FFFF, 8'd10));
    plan.push_back(rec_row(8'hFF, 32'hFFFF_0000, 8'd4));
    // size change in the middle of a packet
    plan.push_back(cfg_row(REG_RECORD_SIZE, 32'd3));
    plan.push_back(cfg_row(REG_SERVO_COUNT, 32'd3));
    plan.push_back(rec_row(8'h11, 32'h00FF_00FF, 8'd11));
    plan.push_back(rec_row(8'h22, 32'hFF00_FF00, 8'd4));
    plan.push_back(cfg_row(REG_RECORD_SIZE, 32'd4));
    plan.push_back(rec_row(8'h33, 32'hC0FF_EE00, 8'd6));

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        drain();
        cfg_write(plan[i].sel, plan[i].data);
      end else begin
        push_record(plan[i].id, plan[i].data, n_pred);
        if (n_pred != plan[i].n_bytes)
          report_miss($sformatf("row %0d frames %0d bytes, table has %0d",
                                i, n_pred, plan[i].n_bytes));
      end
    end

    phase     = 0;
    rand_sent = 0;
    while (rand_sent < RANDOM_ITEMS) begin
      drain();
      random_settings();
      n_recs  = (phase == 1) ? 30 : $urandom_range(20, 8);
      no_idle = (phase == 1);
      if (phase == 2) hold_req = 1'b1;
      for (int j = 0; j < n_recs; j++) begin
        // sender stops and waits for the stream to empty
        if (phase == 3 && j == n_recs / 2) drain();
        push_record(8'($urandom_range(255)), $urandom, n_pred);
        rand_sent++;
      end
      no_idle = 1'b0;
      phase++;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("records %0d, bytes %0d, packets closed %0d, register writes %0d",
             records_sent, bytes_seen, packets_closed, writes_done);
    $display("long output holds %0d, mismatches %0d, cycles %0d",
             holds_done, errors, cycles);
    if (errors == 0 && stream_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
